@@ hw/rtl/tqpd_pkg.sv @@
`timescale 1ns / 1ps
package tqpd_pkg;

	localparam int QueueCount = 3;
	localparam int DefQueueDepth = 64;
	localparam int DefNumberBits = 16;
	localparam int DefPriorityBits = 8;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_SERVE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [1:0] STAT_SERVED = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] queue_select;
		logic [7:0] priority_req;
	} req_item_t;

	typedef struct packed {
		logic [15:0] item_number;
		logic [1:0] status;
	} rsp_item_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] queue;
	} cmd_t;

endpackage

@@ hw/rtl/tqpd_front.sv @@
`timescale 1ns / 1ps
module tqpd_front #(
	parameter int PRIORITY_BITS = tqpd_pkg::DefPriorityBits
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input tqpd_pkg::req_item_t req_data,
	output logic cmd_valid,
	input logic cmd_take,
	output tqpd_pkg::cmd_t cmd,
	output logic [PRIORITY_BITS-1:0] cmd_prio
);
	import tqpd_pkg::*;

	cmd_t fifo_cmd_q [2];
	logic [PRIORITY_BITS-1:0] fifo_prio_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic accept;
	logic keep;
	logic push;
	logic pop;
	logic [15:0] prio_ext;

	// Inserts and serves on queue three and unknown kinds do nothing, so they are dropped here.
	assign accept = req_valid && !req_stall;
	assign keep = (req_data.kind == KIND_CLEAR) ||
		((req_data.kind == KIND_INSERT || req_data.kind == KIND_SERVE) &&
		req_data.queue_select != 2'd3);
	assign push = accept && keep;
	assign pop = cmd_valid && cmd_take;
	assign req_stall = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_cmd_q[rd_ptr_q];
	assign cmd_prio = fifo_prio_q[rd_ptr_q];
	assign prio_ext = 16'(req_data.priority_req);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_cmd_q[wr_ptr_q] <= '{op: req_data.kind, queue: req_data.queue_select};
			fifo_prio_q[wr_ptr_q] <= prio_ext[PRIORITY_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

@@ hw/rtl/tqpd_back.sv @@
`timescale 1ns / 1ps
module tqpd_back #(
	parameter int QUEUE_DEPTH = tqpd_pkg::DefQueueDepth,
	parameter int NUMBER_BITS = tqpd_pkg::DefNumberBits,
	parameter int PRIORITY_BITS = tqpd_pkg::DefPriorityBits
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_take,
	input tqpd_pkg::cmd_t cmd,
	input logic [PRIORITY_BITS-1:0] cmd_prio,
	output logic rsp_valid,
	input logic rsp_stall,
	output tqpd_pkg::rsp_item_t rsp_data
);
	import tqpd_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(QueueCount * QUEUE_DEPTH);
	localparam int EW = NUMBER_BITS + PRIORITY_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	logic [EW-1:0] mem [QueueCount * QUEUE_DEPTH];
	logic [EW-1:0] rd_data_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic wr_en;

	logic [1:0] state_q;
	logic [CW-1:0] count_q [QueueCount];
	logic [NUMBER_BITS-1:0] counter_q;
	logic [1:0] q_q;
	logic [CW-1:0] n_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] best_idx_q;
	logic [NUMBER_BITS-1:0] best_num_q;
	logic [PRIORITY_BITS-1:0] best_pr_q;
	rsp_item_t res_q;
	rsp_item_t rsp_q;
	logic rsp_valid_q;

	logic [CW-1:0] cur_count;
	logic [PRIORITY_BITS-1:0] cand_pr;
	logic [NUMBER_BITS-1:0] cand_num;
	logic cand_wins;
	logic scan_last;
	logic rsp_load;
	logic [31:0] best_num_ext;

	function automatic logic [AW-1:0] base_of(input logic [1:0] q);
		logic [AW-1:0] b;
		unique case (q)
			2'd0: b = '0;
			2'd1: b = AW'(QUEUE_DEPTH);
			default: b = AW'(2 * QUEUE_DEPTH);
		endcase
		return b;
	endfunction

	assign cur_count = count_q[cmd.queue[1] ? 2'd2 : cmd.queue];
	assign cand_pr = rd_data_q[PRIORITY_BITS-1:0];
	assign cand_num = rd_data_q[EW-1:PRIORITY_BITS];
	assign cand_wins = (idx_q == '0) || (cand_pr > best_pr_q) ||
		(cand_pr == best_pr_q && cand_num < best_num_q);
	assign scan_last = (CW'(idx_q) + CW'(1)) == n_q;
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid;
	assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;
	assign best_num_ext = 32'(best_num_q);

	always_comb begin
		rd_addr = base_of(q_q) + AW'(idx_q + IW'(1));
		wr_en = 1'b0;
		wr_addr = base_of(cmd.queue) + AW'(cur_count);
		wr_data = {counter_q + NUMBER_BITS'(1), cmd_prio};
		if (state_q == ST_IDLE) begin
			rd_addr = base_of(cmd.queue);
			wr_en = cmd_take && cmd.op == KIND_INSERT &&
				cur_count != CW'(QUEUE_DEPTH) && counter_q != '1;
		end else if (state_q == ST_SCAN && scan_last) begin
			rd_addr = base_of(q_q) + AW'(IW'(n_q - CW'(1)));
		end else if (state_q == ST_LAST) begin
			wr_en = 1'b1;
			wr_addr = base_of(q_q) + AW'(best_idx_q);
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && cand_wins) begin
			best_idx_q <= idx_q;
			best_num_q <= cand_num;
			best_pr_q <= cand_pr;
		end
		if (rsp_load) rsp_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < QueueCount; i++) count_q[i] <= '0;
			counter_q <= '0;
			q_q <= '0;
			n_q <= '0;
			idx_q <= '0;
			res_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						q_q <= cmd.queue;
						if (cmd.op == KIND_CLEAR) begin
							for (int i = 0; i < QueueCount; i++) count_q[i] <= '0;
							counter_q <= '0;
						end else if (cmd.op == KIND_INSERT) begin
							if (cur_count == CW'(QUEUE_DEPTH)) begin
								res_q <= '{item_number: 16'd0, status: STAT_FULL};
								state_q <= ST_RESP;
							end else if (counter_q == '1) begin
								res_q <= '{item_number: 16'd0, status: STAT_EXHAUSTED};
								state_q <= ST_RESP;
							end else begin
								counter_q <= counter_q + NUMBER_BITS'(1);
								count_q[cmd.queue] <= cur_count + CW'(1);
							end
						end else if (cur_count == '0) begin
							res_q <= '{item_number: 16'd0, status: STAT_EMPTY};
							state_q <= ST_RESP;
						end else begin
							n_q <= cur_count;
							idx_q <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) state_q <= ST_LAST;
					else idx_q <= idx_q + IW'(1);
				end
				ST_LAST: begin
					count_q[q_q] <= n_q - CW'(1);
					res_q <= '{item_number: best_num_ext[15:0], status: STAT_SERVED};
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/three_queue_priority_dispatcher_core.sv @@
`timescale 1ns / 1ps
// Three bounded priority queues sharing one arrival counter. A successful insert and a clear
// finish in the back end's idle state; a failed insert or an empty serve goes on to the response
// state. A serve reads every entry of the chosen queue through the single read port of the entry
// memory, one per cycle. A two-entry command queue decouples the request side, and a result
// register decouples the response side.
module three_queue_priority_dispatcher_core #(
	parameter int QUEUE_DEPTH = tqpd_pkg::DefQueueDepth,
	parameter int NUMBER_BITS = tqpd_pkg::DefNumberBits,
	parameter int PRIORITY_BITS = tqpd_pkg::DefPriorityBits
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input tqpd_pkg::req_item_t req_data,
	output logic rsp_valid,
	input logic rsp_stall,
	output tqpd_pkg::rsp_item_t rsp_data
);
	import tqpd_pkg::*;

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;
	logic [PRIORITY_BITS-1:0] cmd_prio;

	tqpd_front #(
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take),
		.cmd(cmd),
		.cmd_prio(cmd_prio)
	);

	tqpd_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.NUMBER_BITS(NUMBER_BITS),
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take),
		.cmd(cmd),
		.cmd_prio(cmd_prio),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

endmodule
